// ===== src/uvs_pkg.sv =====
// uvs_pkg: shared constants, types and the arctangent constants of the uv sphere generator
package uvs_pkg;

   localparam int COUNT_BITS   = 8;
   localparam int FRAC_BITS    = 14;
   localparam int CORDIC_STEPS = 30;
   localparam int PHASE_BITS   = 32;
   localparam int PHI_QBITS    = 32;
   localparam int THETA_QBITS  = 34;
   localparam int POS_W        = 16;
   localparam int TEX_W        = 15;
   localparam int IDX_W        = 16;
   localparam int CSR_ADDR_W   = 2;
   localparam int XY_W         = 34;
   localparam int Z_W          = 33;
   localparam int TRIG_W       = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_STACK_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLICE_COUNT = 2'd1;

   localparam logic OP_VERTEX = 1'b0;
   localparam logic OP_CELL   = 1'b1;

   localparam logic [COUNT_BITS-1:0] STACK_RESET = 8'd16;
   localparam logic [COUNT_BITS-1:0] SLICE_RESET = 8'd32;
   localparam logic [COUNT_BITS-1:0] STACK_MIN   = 8'd1;
   localparam logic [COUNT_BITS-1:0] SLICE_MIN   = 8'd3;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic      op;
      logic      oog;
      count_type st;
      count_type sl;
      count_type stacks;
      count_type slices;
   } task_type;

   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] r;
      case (i)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         24: r = 32'h00000029;
         25: r = 32'h00000014;
         26: r = 32'h0000000A;
         27: r = 32'h00000005;
         28: r = 32'h00000003;
         29: r = 32'h00000001;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/uv_sphere_mesh_generator.sv =====
// uv_sphere_mesh_generator: top level of the uv sphere vertex and cell generator
// throughput: one request per cycle, set by the 34-stage divider and 30-stage cordic
// pipeline that advance together whenever the response register is free
// reset: synchronous, clears the queue and all pipeline valids; counts return to 16 and 32
module uv_sphere_mesh_generator import uvs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_ADDR_W-1:0]   csr_index,
   input  logic [COUNT_BITS-1:0]   csr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_operation,
   input  logic [COUNT_BITS-1:0]   req_stack_index,
   input  logic [COUNT_BITS-1:0]   req_slice_index,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [POS_W-1:0] rsp_pos_x,
   output logic signed [POS_W-1:0] rsp_pos_y,
   output logic signed [POS_W-1:0] rsp_pos_z,
   output logic [TEX_W-1:0]        rsp_tex_u,
   output logic [TEX_W-1:0]        rsp_tex_v,
   output logic [IDX_W-1:0]        rsp_corner_a,
   output logic [IDX_W-1:0]        rsp_corner_b,
   output logic [IDX_W-1:0]        rsp_corner_a_next,
   output logic [IDX_W-1:0]        rsp_corner_b_next,
   output logic                    rsp_out_of_grid
);

   logic     push, full, pop, empty;
   task_type push_task, head;

   uvs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_stack_index (req_stack_index),
      .req_slice_index (req_slice_index),
      .queue_full      (full),
      .push            (push),
      .push_task       (push_task)
   );

   uvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   uvs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (empty),
      .queue_head        (head),
      .queue_pop         (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_pos_z         (rsp_pos_z),
      .rsp_tex_u         (rsp_tex_u),
      .rsp_tex_v         (rsp_tex_v),
      .rsp_corner_a      (rsp_corner_a),
      .rsp_corner_b      (rsp_corner_b),
      .rsp_corner_a_next (rsp_corner_a_next),
      .rsp_corner_b_next (rsp_corner_b_next),
      .rsp_out_of_grid   (rsp_out_of_grid)
   );

endmodule

// ===== src/uvs_front.sv =====
// uvs_front: count registers, clamping and grid classification of each request
module uvs_front import uvs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [COUNT_BITS-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [COUNT_BITS-1:0] req_stack_index,
   input  logic [COUNT_BITS-1:0] req_slice_index,
   input  logic                  queue_full,
   output logic                  push,
   output task_type              push_task
);

   count_type stack_count_ff, stack_count_in;
   count_type slice_count_ff, slice_count_in;
   count_type stacks, slices;
   logic      vertex_oog, quad_oog;

   assign csr_ready = 1'b1;

   always_comb begin
      stack_count_in = stack_count_ff;
      slice_count_in = slice_count_ff;
      if (csr_valid && csr_index == CSR_STACK_COUNT) begin
         stack_count_in = csr_data;
      end
      if (csr_valid && csr_index == CSR_SLICE_COUNT) begin
         slice_count_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= STACK_RESET;
         slice_count_ff <= SLICE_RESET;
      end else begin
         stack_count_ff <= stack_count_in;
         slice_count_ff <= slice_count_in;
      end
   end

   assign stacks = (stack_count_ff < STACK_MIN) ? STACK_MIN : stack_count_ff;
   assign slices = (slice_count_ff < SLICE_MIN) ? SLICE_MIN : slice_count_ff;

   assign vertex_oog = (req_stack_index > stacks) || (req_slice_index > slices);
   assign quad_oog   = (req_stack_index >= stacks) || (req_slice_index >= slices);

   assign req_ready = ~queue_full;
   assign push      = req_valid & ~queue_full;

   always_comb begin
      push_task.op     = req_operation;
      push_task.oog    = (req_operation == OP_VERTEX) ? vertex_oog : quad_oog;
      push_task.st     = req_stack_index;
      push_task.sl     = req_slice_index;
      push_task.stacks = stacks;
      push_task.slices = slices;
   end

endmodule

// ===== src/uvs_queue.sv =====
// uvs_queue: two-entry request queue between front and back
module uvs_queue import uvs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_task,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output task_type head
);

   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   task_type   slot_ff [2];

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_task;
      end
   end

endmodule

// ===== src/uvs_back.sv =====
// uvs_back: divider, cordic and product pipeline with the response register
module uvs_back import uvs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    queue_empty,
   input  task_type                queue_head,
   output logic                    queue_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [POS_W-1:0] rsp_pos_x,
   output logic signed [POS_W-1:0] rsp_pos_y,
   output logic signed [POS_W-1:0] rsp_pos_z,
   output logic [TEX_W-1:0]        rsp_tex_u,
   output logic [TEX_W-1:0]        rsp_tex_v,
   output logic [IDX_W-1:0]        rsp_corner_a,
   output logic [IDX_W-1:0]        rsp_corner_b,
   output logic [IDX_W-1:0]        rsp_corner_a_next,
   output logic [IDX_W-1:0]        rsp_corner_b_next,
   output logic                    rsp_out_of_grid
);

   localparam int AW   = 2 * COUNT_BITS + 2;
   localparam int UQ_W = FRAC_BITS + 2;
   localparam int PW   = 2 * TRIG_W;
   localparam int SH   = 2 * (PHASE_BITS - 2) - FRAC_BITS;
   localparam logic signed [PW-1:0] HALF_P = PW'(1) << (SH - 1);
   localparam logic signed [PW-1:0] ONE_P  = PW'(1) << FRAC_BITS;

   typedef struct packed {
      logic                  valid;
      task_type              t;
      logic [IDX_W-1:0]      a;
      logic [IDX_W-1:0]      b;
      count_type             rem_p;
      count_type             rem_t;
      logic [PHI_QBITS:0]    q_p;
      logic [THETA_QBITS:0]  q_t;
   } div_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } rot_type;

   typedef struct packed {
      logic             valid;
      logic             op;
      logic             oog;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [TEX_W-1:0] u;
      logic [TEX_W-1:0] v;
      logic [1:0]       quad_p;
      logic [1:0]       quad_t;
      rot_type          p;
      rot_type          t;
   } cdc_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sn;
      logic signed [TRIG_W-1:0] cs;
   } sc_type;

   typedef struct packed {
      logic             valid;
      logic             op;
      logic             oog;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [TEX_W-1:0] u;
      logic [TEX_W-1:0] v;
      sc_type           phi;
      sc_type           theta;
   } trig_type;

   typedef struct packed {
      logic                 valid;
      logic                 op;
      logic                 oog;
      logic [IDX_W-1:0]     a;
      logic [IDX_W-1:0]     b;
      logic [TEX_W-1:0]     u;
      logic [TEX_W-1:0]     v;
      logic signed [PW-1:0] px;
      logic signed [PW-1:0] py;
      logic signed [PW-1:0] pz;
   } mul_type;

   function automatic rot_type rotate(input rot_type r, input int s,
                                      input logic signed [Z_W-1:0] at);
      rot_type o;
      if (!r.z[Z_W-1]) begin
         o.x = r.x - (r.y >>> s);
         o.y = r.y + (r.x >>> s);
         o.z = r.z - at;
      end else begin
         o.x = r.x + (r.y >>> s);
         o.y = r.y - (r.x >>> s);
         o.z = r.z + at;
      end
      return o;
   endfunction

   function automatic sc_type quadrant(input logic [1:0] quad, input rot_type r);
      sc_type o;
      case (quad)
         2'd0: begin
            o.cs = TRIG_W'(r.x);
            o.sn = TRIG_W'(r.y);
         end
         2'd1: begin
            o.cs = TRIG_W'(-r.y);
            o.sn = TRIG_W'(r.x);
         end
         2'd2: begin
            o.cs = TRIG_W'(-r.x);
            o.sn = TRIG_W'(-r.y);
         end
         default: begin
            o.cs = TRIG_W'(r.y);
            o.sn = TRIG_W'(-r.x);
         end
      endcase
      return o;
   endfunction

   function automatic logic signed [POS_W-1:0] frac_round(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] r;
      r = (p + HALF_P) >>> SH;
      if (r > ONE_P) begin
         r = ONE_P;
      end else if (r < -ONE_P) begin
         r = -ONE_P;
      end
      return POS_W'(r);
   endfunction

   logic en;

   div_type  div_ff [THETA_QBITS+1];
   div_type  div_in [THETA_QBITS+1];
   cdc_type  cdc_ff [CORDIC_STEPS+1];
   cdc_type  cdc_in [CORDIC_STEPS+1];
   trig_type trig_ff, trig_in;
   mul_type  mul_ff, mul_in;

   logic [AW-1:0] a_wide, b_wide;
   logic          ge_p0, ge_t0;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic [TEX_W-1:0]        tex_u_ff, tex_u_in, tex_v_ff, tex_v_in;
   logic [IDX_W-1:0]        ca_ff, ca_in, cb_ff, cb_in, can_ff, can_in, cbn_ff, cbn_in;
   logic                    oog_ff, oog_in;

   assign en        = ~rsp_valid_ff | rsp_ready;
   assign queue_pop = en & ~queue_empty;

   // entry stage: corner indices and integer bit of both quotients
   always_comb begin
      a_wide = AW'(queue_head.st) * (AW'(queue_head.slices) + AW'(1)) + AW'(queue_head.sl);
      b_wide = a_wide + AW'(queue_head.slices) + AW'(1);
      ge_p0  = queue_head.st >= queue_head.stacks;
      ge_t0  = queue_head.sl >= queue_head.slices;
      div_in[0].valid = ~queue_empty;
      div_in[0].t     = queue_head;
      div_in[0].a     = a_wide[IDX_W-1:0];
      div_in[0].b     = b_wide[IDX_W-1:0];
      div_in[0].rem_p = ge_p0 ? queue_head.st - queue_head.stacks : queue_head.st;
      div_in[0].rem_t = ge_t0 ? queue_head.sl - queue_head.slices : queue_head.sl;
      div_in[0].q_p   = {{PHI_QBITS{1'b0}}, ge_p0};
      div_in[0].q_t   = {{THETA_QBITS{1'b0}}, ge_t0};
   end

   // restoring division, one theta quotient bit per stage; the phi quotient stops at PHI_QBITS bits
   for (genvar k = 1; k <= THETA_QBITS; k++) begin : g_div
      logic [COUNT_BITS:0] rem2_p, rem2_t;
      logic                ge_p, ge_t;

      always_comb begin
         div_in[k] = div_ff[k-1];
         rem2_t = {div_ff[k-1].rem_t, 1'b0};
         ge_t   = rem2_t >= {1'b0, div_ff[k-1].t.slices};
         div_in[k].rem_t = ge_t ? COUNT_BITS'(rem2_t - {1'b0, div_ff[k-1].t.slices})
                                : rem2_t[COUNT_BITS-1:0];
         div_in[k].q_t   = {div_ff[k-1].q_t[THETA_QBITS-1:0], ge_t};
         rem2_p = {div_ff[k-1].rem_p, 1'b0};
         ge_p   = rem2_p >= {1'b0, div_ff[k-1].t.stacks};
         if (k <= PHI_QBITS) begin
            div_in[k].rem_p = ge_p ? COUNT_BITS'(rem2_p - {1'b0, div_ff[k-1].t.stacks})
                                   : rem2_p[COUNT_BITS-1:0];
            div_in[k].q_p   = {div_ff[k-1].q_p[PHI_QBITS-1:0], ge_p};
         end
      end
   end

   for (genvar k = 0; k <= THETA_QBITS; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k].valid <= 1'b0;
         end else if (en) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // rounded phases and texture coordinates
   logic [PHI_QBITS:0]   qp1;
   logic [THETA_QBITS:0] qt1;
   logic [UQ_W-1:0]      u1, v1;
   logic [PHASE_BITS-1:0] phase_p, phase_t;

   always_comb begin
      qp1     = div_ff[THETA_QBITS].q_p + 1'b1;
      qt1     = div_ff[THETA_QBITS].q_t + 2'd2;
      phase_p = qp1[PHASE_BITS:1];
      phase_t = qt1[PHASE_BITS+1:2];
      u1      = div_ff[THETA_QBITS].q_t[THETA_QBITS -: UQ_W] + 1'b1;
      v1      = div_ff[THETA_QBITS].q_p[PHI_QBITS -: UQ_W] + 1'b1;
      cdc_in[0].valid  = div_ff[THETA_QBITS].valid;
      cdc_in[0].op     = div_ff[THETA_QBITS].t.op;
      cdc_in[0].oog    = div_ff[THETA_QBITS].t.oog;
      cdc_in[0].a      = div_ff[THETA_QBITS].a;
      cdc_in[0].b      = div_ff[THETA_QBITS].b;
      cdc_in[0].u      = u1[TEX_W:1];
      cdc_in[0].v      = v1[TEX_W:1];
      cdc_in[0].quad_p = phase_p[PHASE_BITS-1 -: 2];
      cdc_in[0].quad_t = phase_t[PHASE_BITS-1 -: 2];
      cdc_in[0].p.x    = CORDIC_GAIN;
      cdc_in[0].p.y    = '0;
      cdc_in[0].p.z    = Z_W'(phase_p[PHASE_BITS-3:0]);
      cdc_in[0].t.x    = CORDIC_GAIN;
      cdc_in[0].t.y    = '0;
      cdc_in[0].t.z    = Z_W'(phase_t[PHASE_BITS-3:0]);
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [Z_W-1:0] at_c;
      assign at_c = $signed({1'b0, atan_turn(i)});

      always_comb begin
         cdc_in[i+1]   = cdc_ff[i];
         cdc_in[i+1].p = rotate(cdc_ff[i].p, i, at_c);
         cdc_in[i+1].t = rotate(cdc_ff[i].t, i, at_c);
      end
   end

   for (genvar i = 0; i <= CORDIC_STEPS; i++) begin : g_cordic_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            cdc_ff[i].valid <= 1'b0;
         end else if (en) begin
            cdc_ff[i] <= cdc_in[i];
         end
      end
   end

   always_comb begin
      trig_in.valid = cdc_ff[CORDIC_STEPS].valid;
      trig_in.op    = cdc_ff[CORDIC_STEPS].op;
      trig_in.oog   = cdc_ff[CORDIC_STEPS].oog;
      trig_in.a     = cdc_ff[CORDIC_STEPS].a;
      trig_in.b     = cdc_ff[CORDIC_STEPS].b;
      trig_in.u     = cdc_ff[CORDIC_STEPS].u;
      trig_in.v     = cdc_ff[CORDIC_STEPS].v;
      trig_in.phi   = quadrant(cdc_ff[CORDIC_STEPS].quad_p, cdc_ff[CORDIC_STEPS].p);
      trig_in.theta = quadrant(cdc_ff[CORDIC_STEPS].quad_t, cdc_ff[CORDIC_STEPS].t);
   end

   always_comb begin
      mul_in.valid = trig_ff.valid;
      mul_in.op    = trig_ff.op;
      mul_in.oog   = trig_ff.oog;
      mul_in.a     = trig_ff.a;
      mul_in.b     = trig_ff.b;
      mul_in.u     = trig_ff.u;
      mul_in.v     = trig_ff.v;
      mul_in.px    = trig_ff.phi.sn * trig_ff.theta.cs;
      mul_in.py    = trig_ff.phi.sn * trig_ff.theta.sn;
      mul_in.pz    = PW'(trig_ff.phi.cs) <<< (PHASE_BITS - 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff.valid <= 1'b0;
         mul_ff.valid  <= 1'b0;
      end else if (en) begin
         trig_ff <= trig_in;
         mul_ff  <= mul_in;
      end
   end

   always_comb begin
      rsp_valid_in = mul_ff.valid;
      pos_x_in     = '0;
      pos_y_in     = '0;
      pos_z_in     = '0;
      tex_u_in     = '0;
      tex_v_in     = '0;
      ca_in        = '0;
      cb_in        = '0;
      can_in       = '0;
      cbn_in       = '0;
      oog_in       = mul_ff.oog;
      if (!mul_ff.oog) begin
         if (mul_ff.op == OP_VERTEX) begin
            pos_x_in = frac_round(mul_ff.px);
            pos_y_in = frac_round(mul_ff.py);
            pos_z_in = frac_round(mul_ff.pz);
            tex_u_in = mul_ff.u;
            tex_v_in = mul_ff.v;
         end else begin
            ca_in  = mul_ff.a;
            cb_in  = mul_ff.b;
            can_in = mul_ff.a + IDX_W'(1);
            cbn_in = mul_ff.b + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         tex_u_ff <= tex_u_in;
         tex_v_ff <= tex_v_in;
         ca_ff    <= ca_in;
         cb_ff    <= cb_in;
         can_ff   <= can_in;
         cbn_ff   <= cbn_in;
         oog_ff   <= oog_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pos_x         = pos_x_ff;
   assign rsp_pos_y         = pos_y_ff;
   assign rsp_pos_z         = pos_z_ff;
   assign rsp_tex_u         = tex_u_ff;
   assign rsp_tex_v         = tex_v_ff;
   assign rsp_corner_a      = ca_ff;
   assign rsp_corner_b      = cb_ff;
   assign rsp_corner_a_next = can_ff;
   assign rsp_corner_b_next = cbn_ff;
   assign rsp_out_of_grid   = oog_ff;

endmodule
